// ----- rtl/core/dwbr_pkg.sv -----
// display word bit remapper package
// register indexes, reset values and the configuration struct; no dependencies
`timescale 1ns / 1ps

package dwbr_pkg;

	localparam int unsigned WORD_W  = 16;
	localparam int unsigned SRC_W   = 32;
	localparam int unsigned REG_W   = 32;
	localparam int unsigned FIELD_W = 5;
	localparam int unsigned SEL_W   = 2;
	localparam int unsigned WIDTH_W = 5;
	localparam int unsigned IDX_W   = 3;

	localparam logic [REG_W-1:0]   MAP_LOW_RST  = 32'd344131616;
	localparam logic [REG_W-1:0]   MAP_MID_RST  = 32'd759767270;
	localparam logic [REG_W-1:0]   MAP_HIGH_RST = 32'd1175402924;
	localparam logic [WIDTH_W-1:0] WIDTH_RST    = 5'd1;

	typedef enum logic [IDX_W-1:0] {
		REG_MAP_LOW    = 3'd0,
		REG_MAP_MID    = 3'd1,
		REG_MAP_HIGH   = 3'd2,
		REG_SRC_SELECT = 3'd3,
		REG_CONST_BITS = 3'd4,
		REG_WORD_WIDTH = 3'd5,
		REG_PAIR_MODE  = 3'd6
	} reg_idx_t;

	typedef enum logic [SEL_W-1:0] {
		SEL_MAPPED = 2'd0,
		SEL_CONST  = 2'd1,
		SEL_ZERO_A = 2'd2,
		SEL_ZERO_B = 2'd3
	} bit_sel_t;

	typedef struct packed {
		logic [REG_W-1:0]   map_low;
		logic [REG_W-1:0]   map_mid;
		logic [REG_W-1:0]   map_high;
		logic [REG_W-1:0]   src_select;
		logic [WORD_W-1:0]  const_bits;
		logic [WIDTH_W-1:0] word_width;
		logic               pair_mode;
	} cfg_t;

endpackage

// ----- rtl/core/dwbr_if.sv -----
// valid/ready channels for transmit items and display items
// depends on dwbr_pkg
`timescale 1ns / 1ps

interface dwbr_tx_if;
	logic                       valid;
	logic                       ready;
	logic [dwbr_pkg::WORD_W-1:0] in_word;

	modport source (output valid, output in_word, input ready);
	modport sink (input valid, input in_word, output ready);
endinterface

interface dwbr_disp_if;
	logic                       valid;
	logic                       ready;
	logic [dwbr_pkg::WORD_W-1:0] out_word;

	modport source (output valid, output out_word, input ready);
	modport sink (input valid, input out_word, output ready);
endinterface

// ----- rtl/core/dwbr_cfg.sv -----
// configuration register bank with plain write port
// depends on dwbr_pkg
`timescale 1ns / 1ps

module dwbr_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [dwbr_pkg::IDX_W-1:0]  wr_index,
	input  logic [dwbr_pkg::REG_W-1:0]  wr_data,
	output dwbr_pkg::cfg_t              cfg,
	output logic                        pair_clr
);

	dwbr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_low    <= dwbr_pkg::MAP_LOW_RST;
			cfg_q.map_mid    <= dwbr_pkg::MAP_MID_RST;
			cfg_q.map_high   <= dwbr_pkg::MAP_HIGH_RST;
			cfg_q.src_select <= '0;
			cfg_q.const_bits <= '0;
			cfg_q.word_width <= dwbr_pkg::WIDTH_RST;
			cfg_q.pair_mode  <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				dwbr_pkg::REG_MAP_LOW:    cfg_q.map_low    <= wr_data;
				dwbr_pkg::REG_MAP_MID:    cfg_q.map_mid    <= wr_data;
				dwbr_pkg::REG_MAP_HIGH:   cfg_q.map_high   <= wr_data;
				dwbr_pkg::REG_SRC_SELECT: cfg_q.src_select <= wr_data;
				dwbr_pkg::REG_CONST_BITS: cfg_q.const_bits <= wr_data[dwbr_pkg::WORD_W-1:0];
				dwbr_pkg::REG_WORD_WIDTH: cfg_q.word_width <= wr_data[dwbr_pkg::WIDTH_W-1:0];
				dwbr_pkg::REG_PAIR_MODE:  cfg_q.pair_mode  <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg      = cfg_q;
	assign pair_clr = wr_en && (wr_index == dwbr_pkg::REG_PAIR_MODE);

endmodule

// ----- rtl/core/dwbr_remap.sv -----
// per-bit source selection and width mask for one display word
// depends on dwbr_pkg
`timescale 1ns / 1ps

module dwbr_remap (
	input  dwbr_pkg::cfg_t               cfg,
	input  logic [dwbr_pkg::SRC_W-1:0]   src,
	output logic [dwbr_pkg::WORD_W-1:0]  word
);

	always_comb begin
		logic [dwbr_pkg::REG_W-1:0]   map_reg;
		logic [dwbr_pkg::FIELD_W-1:0] idx;
		logic [dwbr_pkg::SEL_W-1:0]   sel;
		int unsigned                  off;
		word = '0;
		for (int unsigned b = 0; b < dwbr_pkg::WORD_W; b++) begin
			off = (b % 6) * dwbr_pkg::FIELD_W;
			if (off >= 15)
				off = off + 1;
			case (b / 6)
				0:       map_reg = cfg.map_low;
				1:       map_reg = cfg.map_mid;
				default: map_reg = cfg.map_high;
			endcase
			idx = map_reg[off +: dwbr_pkg::FIELD_W];
			sel = cfg.src_select[b*dwbr_pkg::SEL_W +: dwbr_pkg::SEL_W];
			if (b < 32'(cfg.word_width)) begin
				case (sel)
					dwbr_pkg::SEL_MAPPED: word[b] = src[idx];
					dwbr_pkg::SEL_CONST:  word[b] = cfg.const_bits[b];
					default:              word[b] = 1'b0;
				endcase
			end
		end
	end

endmodule

// ----- rtl/core/display_word_bit_remapper.sv -----
// display word bit remapper: 16-bit transmit items to masked display items
// an accepted item goes through the input stage, then the result register; one item per cycle unless disp stalls
// in pair mode the first item of a pair is held and gives no result
// registers: input stage (_s1) and result register (_s2), ready follows out ready
// async active-low reset: identity map, width 1, pair mode off, nothing held
`timescale 1ns / 1ps

module display_word_bit_remapper (
	input  logic                        clk,
	input  logic                        arst_n,
	dwbr_tx_if.sink                     tx,
	dwbr_disp_if.source                 disp,
	input  logic                        wr_en,
	input  logic [dwbr_pkg::IDX_W-1:0]  wr_index,
	input  logic [dwbr_pkg::REG_W-1:0]  wr_data
);

	dwbr_pkg::cfg_t                cfg;
	logic                          pair_clr;
	logic [dwbr_pkg::WORD_W-1:0]   held_word_q;
	logic                          held_valid_q;
	logic [dwbr_pkg::SRC_W-1:0]    src_s1;
	logic                          valid_s1;
	logic [dwbr_pkg::WORD_W-1:0]   word_s2;
	logic                          valid_s2;
	logic [dwbr_pkg::WORD_W-1:0]   remap_word;
	logic                          adv_s1;
	logic                          tx_acc;
	logic                          emit;

	dwbr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg),
		.pair_clr (pair_clr)
	);

	dwbr_remap u_remap (
		.cfg  (cfg),
		.src  (src_s1),
		.word (remap_word)
	);

	assign adv_s1   = !valid_s2 || disp.ready;
	assign tx.ready = !valid_s1 || adv_s1;
	assign tx_acc   = tx.valid && tx.ready;
	assign emit     = !cfg.pair_mode || held_valid_q;

	// pair assembly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_word_q  <= '0;
		end else if (pair_clr) begin
			held_valid_q <= 1'b0;
			held_word_q  <= '0;
		end else if (tx_acc && cfg.pair_mode) begin
			held_valid_q <= !held_valid_q;
			if (!held_valid_q)
				held_word_q <= tx.in_word;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tx_acc && emit) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tx_acc && emit) begin
			if (cfg.pair_mode)
				src_s1 <= {tx.in_word, held_word_q};
			else
				src_s1 <= {{(dwbr_pkg::SRC_W-dwbr_pkg::WORD_W){1'b0}}, tx.in_word};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1)
			word_s2 <= remap_word;
	end

	assign disp.valid    = valid_s2;
	assign disp.out_word = word_s2;

endmodule
